[rtl/cdfp_pkg.sv]
package cdfp_pkg;

    typedef enum logic [2:0] {
        KIND_CONFIRM = 3'd0,
        KIND_REPLY   = 3'd1,
        KIND_AUTH    = 3'd2,
        KIND_JOIN    = 3'd3,
        KIND_MSG     = 3'd4,
        KIND_ERR     = 3'd5,
        KIND_BYE     = 3'd6,
        KIND_UNKNOWN = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        FLD_TYPE    = 4'd0,
        FLD_ID_HI   = 4'd1,
        FLD_ID_LO   = 4'd2,
        FLD_RESULT  = 4'd3,
        FLD_REF_HI  = 4'd4,
        FLD_REF_LO  = 4'd5,
        FLD_USER    = 4'd6,
        FLD_NAME    = 4'd7,
        FLD_SECRET  = 4'd8,
        FLD_CHANNEL = 4'd9,
        FLD_CONTENT = 4'd10,
        FLD_SURPLUS = 4'd11
    } t_field;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_KIND  = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam logic [7:0] BYTE_CONFIRM = 8'h00;
    localparam logic [7:0] BYTE_REPLY   = 8'h01;
    localparam logic [7:0] BYTE_AUTH    = 8'h02;
    localparam logic [7:0] BYTE_JOIN    = 8'h03;
    localparam logic [7:0] BYTE_MSG     = 8'h04;
    localparam logic [7:0] BYTE_ERR     = 8'hFE;
    localparam logic [7:0] BYTE_BYE     = 8'hFF;
    localparam logic [7:0] BYTE_NUL     = 8'h00;

    localparam logic [2:0] POS_TYPE   = 3'd0;
    localparam logic [2:0] POS_ID_HI  = 3'd1;
    localparam logic [2:0] POS_ID_LO  = 3'd2;
    localparam logic [2:0] POS_RESULT = 3'd3;
    localparam logic [2:0] POS_REF_HI = 3'd4;
    localparam logic [2:0] POS_MAX    = 3'd7;

    localparam logic [3:0] HDR_LEN_BASIC = 4'd3;
    localparam logic [3:0] HDR_LEN_REPLY = 4'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_in_word;

    typedef struct packed {
        t_kind       msg_kind;
        t_field      field_kind;
        logic [7:0]  field_byte;
        logic        is_terminator;
        logic [15:0] message_id;
        logic [15:0] reference_id;
        t_status     parse_status;
        logic        datagram_done;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

    function automatic t_kind decode_kind(logic [7:0] b);
        t_kind k;
        case (b)
            BYTE_CONFIRM: k = KIND_CONFIRM;
            BYTE_REPLY:   k = KIND_REPLY;
            BYTE_AUTH:    k = KIND_AUTH;
            BYTE_JOIN:    k = KIND_JOIN;
            BYTE_MSG:     k = KIND_MSG;
            BYTE_ERR:     k = KIND_ERR;
            BYTE_BYE:     k = KIND_BYE;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // surplus once the kind's text fields are used up
    function automatic t_field text_tag(t_kind k, logic [1:0] idx);
        t_field f;
        f = FLD_SURPLUS;
        case (k)
            KIND_REPLY: begin
                if (idx == 2'd0) f = FLD_CONTENT;
            end
            KIND_AUTH: begin
                case (idx)
                    2'd0:    f = FLD_USER;
                    2'd1:    f = FLD_NAME;
                    2'd2:    f = FLD_SECRET;
                    default: f = FLD_SURPLUS;
                endcase
            end
            KIND_JOIN: begin
                case (idx)
                    2'd0:    f = FLD_CHANNEL;
                    2'd1:    f = FLD_NAME;
                    default: f = FLD_SURPLUS;
                endcase
            end
            KIND_MSG, KIND_ERR: begin
                case (idx)
                    2'd0:    f = FLD_NAME;
                    2'd1:    f = FLD_CONTENT;
                    default: f = FLD_SURPLUS;
                endcase
            end
            default: f = FLD_SURPLUS;
        endcase
        return f;
    endfunction

endpackage

[rtl/cdfp_if.sv]
interface cdfp_in_if;
    import cdfp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface cdfp_out_if;
    import cdfp_pkg::*;

    logic        valid;
    logic        ready;
    t_kind       msg_kind;
    t_field      field_kind;
    logic [7:0]  field_byte;
    logic        is_terminator;
    logic [15:0] message_id;
    logic [15:0] reference_id;
    t_status     parse_status;
    logic        datagram_done;

    modport source (
        output valid, output msg_kind, output field_kind, output field_byte,
        output is_terminator, output message_id, output reference_id,
        output parse_status, output datagram_done, input ready
    );
    modport sink (
        input valid, input msg_kind, input field_kind, input field_byte,
        input is_terminator, input message_id, input reference_id,
        input parse_status, input datagram_done, output ready
    );
endinterface

[rtl/cdfp_in_stage.sv]
module cdfp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cdfp_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic              o_ready,
    output cdfp_pkg::t_in_word o_word,
    output cdfp_pkg::t_stage_ctl o_ctl
);
    import cdfp_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready       = !r_valid || i_advance;
    assign o_word        = r_word;
    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end
endmodule

[rtl/cdfp_decode.sv]
module cdfp_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdfp_pkg::t_stage_ctl i_ctl,
    input  cdfp_pkg::t_in_word   i_word,
    output cdfp_pkg::t_out_word  o_res
);
    import cdfp_pkg::*;

    logic [2:0]  r_pos,  n_pos;
    t_kind       r_kind, n_kind;
    logic [1:0]  r_tidx, n_tidx;
    logic [15:0] r_id,   n_id;
    logic [15:0] r_ref,  n_ref;
    logic        r_bad,  n_bad;

    logic [7:0]  b;
    logic [3:0]  hdr_len;
    t_field      field;
    t_field      text_fld;
    logic        term;
    t_status     status;

    assign b = i_word.data_byte;

    always_comb begin
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_tidx   = r_tidx;
        n_id     = r_id;
        n_ref    = r_ref;
        n_bad    = r_bad;
        field    = FLD_SURPLUS;
        term     = 1'b0;
        status   = ST_OK;
        text_fld = FLD_SURPLUS;

        if (r_pos == POS_TYPE) begin
            n_kind = decode_kind(b);
            n_bad  = (n_kind == KIND_UNKNOWN);
            n_id   = '0;
            n_ref  = '0;
            n_tidx = '0;
            field  = FLD_TYPE;
        end

        hdr_len = (n_kind == KIND_REPLY) ? HDR_LEN_REPLY : HDR_LEN_BASIC;

        if (r_pos != POS_TYPE && !n_bad) begin
            if ({1'b0, r_pos} < hdr_len) begin
                case (r_pos)
                    POS_ID_HI: begin
                        n_id  = {b, 8'h00};
                        field = FLD_ID_HI;
                    end
                    POS_ID_LO: begin
                        n_id  = {n_id[15:8], b};
                        field = FLD_ID_LO;
                    end
                    POS_RESULT: begin
                        field = FLD_RESULT;
                    end
                    POS_REF_HI: begin
                        n_ref = {b, 8'h00};
                        field = FLD_REF_HI;
                    end
                    default: begin
                        n_ref = {n_ref[15:8], b};
                        field = FLD_REF_LO;
                    end
                endcase
                if (n_kind == KIND_CONFIRM) begin
                    n_ref = n_id;
                end
            end else begin
                text_fld = text_tag(n_kind, n_tidx);
                if (text_fld != FLD_SURPLUS) begin
                    field = text_fld;
                    if (b == BYTE_NUL) begin
                        term   = 1'b1;
                        n_tidx = n_tidx + 2'd1;
                    end
                end
            end
        end

        if (i_word.end_of_datagram) begin
            if (n_bad) begin
                status = ST_BAD_KIND;
            end else if (({1'b0, r_pos} + 4'd1) < hdr_len) begin
                status = ST_TRUNCATED;
            end
            n_pos = POS_TYPE;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + 3'd1;
        end
    end

    assign o_res.msg_kind      = n_kind;
    assign o_res.field_kind    = field;
    assign o_res.field_byte    = b;
    assign o_res.is_terminator = term;
    assign o_res.message_id    = n_id;
    assign o_res.reference_id  = n_ref;
    assign o_res.parse_status  = status;
    assign o_res.datagram_done = i_word.end_of_datagram;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_TYPE;
            r_kind <= KIND_CONFIRM;
            r_tidx <= '0;
            r_id   <= '0;
            r_ref  <= '0;
            r_bad  <= 1'b0;
        end else if (i_ctl.valid && i_ctl.advance) begin
            r_pos  <= n_pos;
            r_kind <= n_kind;
            r_tidx <= n_tidx;
            r_id   <= n_id;
            r_ref  <= n_ref;
            r_bad  <= n_bad;
        end
    end
endmodule

[rtl/cdfp_out_stage.sv]
module cdfp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cdfp_pkg::t_out_word i_word,
    input  logic                i_ready,
    output logic                o_advance,
    output logic                o_valid,
    output cdfp_pkg::t_out_word o_word
);
    import cdfp_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_word    = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_word <= i_word;
        end
    end
endmodule

[rtl/chat_datagram_field_parser.sv]
// Each byte in the input stage is decoded into a result held in the output stage register.
// Throughput: one byte per cycle while the result side is ready; the parser state loop
// (position, kind, text field index, IDs) closes between the input and result registers.
// Ready on the input follows the result register's ready through the two stages.
// Reset (synchronous, active low) empties both stages and returns the parser to byte 0.
module chat_datagram_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdfp_in_if.sink     i_in,
    cdfp_out_if.source  o_out
);
    import cdfp_pkg::*;

    t_in_word   in_word;
    t_in_word   stage_word;
    t_stage_ctl stage_ctl;
    t_out_word  res_word;
    t_out_word  out_word;
    logic       advance;
    logic       out_valid;

    assign in_word.data_byte       = i_in.data_byte;
    assign in_word.end_of_datagram = i_in.end_of_datagram;

    cdfp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_word    (in_word),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_word    (stage_word),
        .o_ctl     (stage_ctl)
    );

    cdfp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stage_ctl),
        .i_word  (stage_word),
        .o_res   (res_word)
    );

    cdfp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_ctl.valid),
        .i_word    (res_word),
        .i_ready   (o_out.ready),
        .o_advance (advance),
        .o_valid   (out_valid),
        .o_word    (out_word)
    );

    assign o_out.valid         = out_valid;
    assign o_out.msg_kind      = out_word.msg_kind;
    assign o_out.field_kind    = out_word.field_kind;
    assign o_out.field_byte    = out_word.field_byte;
    assign o_out.is_terminator = out_word.is_terminator;
    assign o_out.message_id    = out_word.message_id;
    assign o_out.reference_id  = out_word.reference_id;
    assign o_out.parse_status  = out_word.parse_status;
    assign o_out.datagram_done = out_word.datagram_done;

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_word.datagram_done |-> out_word.parse_status == ST_OK)
        else $error("status reported before the final byte");

    a_term_is_text_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_word.is_terminator |->
            out_word.field_byte == BYTE_NUL && out_word.field_kind != FLD_SURPLUS)
        else $error("terminator flag on a non-text or nonzero byte");

    a_type_byte_clears_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_word.field_kind == FLD_TYPE |->
            out_word.message_id == 16'h0000 && out_word.reference_id == 16'h0000)
        else $error("IDs not cleared on the type byte");

    a_unknown_all_surplus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_word.msg_kind == KIND_UNKNOWN |->
            out_word.field_kind == FLD_TYPE || out_word.field_kind == FLD_SURPLUS)
        else $error("unknown kind tagged with a real field");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_ctl.valid && !advance |=> stage_ctl.valid && $stable(stage_word))
        else $error("input stage lost a word under stall");
endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdfp_pkg::*;

    localparam int RANDOM_BYTES = 700;
    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 150;

    typedef enum int {RX_OPEN, RX_COIN, RX_RARE, RX_CYCLIC} t_rx_mode;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       lit;
        t_out_word  w;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdfp_in_if  in_if ();
    cdfp_out_if out_if ();

    chat_datagram_field_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as predicted
    logic [2:0]  pp_pos;
    t_kind       pp_kind;
    logic [1:0]  pp_fidx;
    logic [15:0] pp_id;
    logic [15:0] pp_rid;
    logic        pp_bad;

    t_script_row script[$];
    t_out_word   pending_results[$];
    logic [7:0]  frame[$];

    int   mismatch_count = 0;
    int   results_checked = 0;
    int   frames_done = 0;
    int   frames_bad_kind = 0;
    int   frames_truncated = 0;
    int   bytes_sent = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    logic hold_request = 1'b0;

    function automatic t_kind kind_of_byte(logic [7:0] b);
        if (b <= BYTE_MSG) return t_kind'(b[2:0]);
        if (b == BYTE_ERR) return KIND_ERR;
        if (b == BYTE_BYE) return KIND_BYE;
        return KIND_UNKNOWN;
    endfunction

    // text fields of each kind in order, surplus once they run out
    function automatic t_field text_slot(t_kind k, logic [1:0] idx);
        t_field order [3];
        order = '{FLD_SURPLUS, FLD_SURPLUS, FLD_SURPLUS};
        case (k)
            KIND_REPLY:         order[0] = FLD_CONTENT;
            KIND_AUTH:          order = '{FLD_USER, FLD_NAME, FLD_SECRET};
            KIND_JOIN:          order = '{FLD_CHANNEL, FLD_NAME, FLD_SURPLUS};
            KIND_MSG, KIND_ERR: order = '{FLD_NAME, FLD_CONTENT, FLD_SURPLUS};
            default: ;
        endcase
        return (idx == 2'd3) ? FLD_SURPLUS : order[idx];
    endfunction

    function automatic t_out_word parse_byte(logic [7:0] b, logic last);
        t_out_word  w;
        logic [3:0] hdr;
        w = '0;
        w.field_kind = FLD_SURPLUS;
        w.parse_status = ST_OK;
        if (pp_pos == POS_TYPE) begin
            pp_kind = kind_of_byte(b);
            pp_bad = (pp_kind == KIND_UNKNOWN);
            pp_id = '0;
            pp_rid = '0;
            pp_fidx = '0;
            w.field_kind = FLD_TYPE;
        end
        hdr = (pp_kind == KIND_REPLY) ? HDR_LEN_REPLY : HDR_LEN_BASIC;
        if (pp_pos != POS_TYPE && !pp_bad) begin
            if ({1'b0, pp_pos} < hdr) begin
                case (pp_pos)
                    POS_ID_HI: begin
                        pp_id = {b, 8'h00};
                        w.field_kind = FLD_ID_HI;
                    end
                    POS_ID_LO: begin
                        pp_id[7:0] = b;
                        w.field_kind = FLD_ID_LO;
                    end
                    POS_RESULT: begin
                        w.field_kind = FLD_RESULT;
                    end
                    POS_REF_HI: begin
                        pp_rid = {b, 8'h00};
                        w.field_kind = FLD_REF_HI;
                    end
                    default: begin
                        pp_rid[7:0] = b;
                        w.field_kind = FLD_REF_LO;
                    end
                endcase
                if (pp_kind == KIND_CONFIRM) pp_rid = pp_id;
            end else begin
                w.field_kind = text_slot(pp_kind, pp_fidx);
                if (w.field_kind != FLD_SURPLUS && b == BYTE_NUL) begin
                    w.is_terminator = 1'b1;
                    pp_fidx = pp_fidx + 2'd1;
                end
            end
        end
        if (last) begin
            if (pp_bad) w.parse_status = ST_BAD_KIND;
            else if ({1'b0, pp_pos} + 4'd1 < hdr) w.parse_status = ST_TRUNCATED;
            pp_pos = POS_TYPE;
        end else if (pp_pos != POS_MAX) begin
            pp_pos = pp_pos + 3'd1;
        end
        w.msg_kind = pp_kind;
        w.field_byte = b;
        w.message_id = pp_id;
        w.reference_id = pp_rid;
        w.datagram_done = last;
        return w;
    endfunction

    function automatic void row(logic [7:0] b, logic last);
        t_script_row r;
        r.b = b;
        r.last = last;
        r.lit = 1'b0;
        r.w = '0;
        script.push_back(r);
    endfunction

    function automatic void row_chk(logic [7:0] b, logic last, t_kind k, t_field f,
                                    logic [15:0] mid, logic [15:0] rid, t_status st);
        t_script_row r;
        r.b = b;
        r.last = last;
        r.lit = 1'b1;
        r.w = '0;
        r.w.msg_kind = k;
        r.w.field_kind = f;
        r.w.field_byte = b;
        r.w.message_id = mid;
        r.w.reference_id = rid;
        r.w.parse_status = st;
        r.w.datagram_done = last;
        script.push_back(r);
    endfunction

    task automatic send_word(logic [7:0] b, logic last, logic lit, t_out_word lit_w);
        t_out_word predicted;
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.end_of_datagram <= last;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = parse_byte(b, last);
        pending_results.push_back(lit ? lit_w : predicted);
        bytes_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed datagrams, some cut short, some noise
    task automatic build_frame();
        int         style;
        int         cut;
        int         idx;
        t_kind      k;
        logic [7:0] lead;
        frame.delete();
        style = $urandom_range(0, 99);
        if (style < 6) begin
            repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(0, 7))
            0:       lead = BYTE_CONFIRM;
            1:       lead = BYTE_REPLY;
            2:       lead = BYTE_AUTH;
            3:       lead = BYTE_JOIN;
            4:       lead = BYTE_MSG;
            5:       lead = BYTE_ERR;
            6:       lead = BYTE_BYE;
            default: lead = 8'($urandom_range(5, 253));
        endcase
        k = kind_of_byte(lead);
        frame.push_back(lead);
        repeat ((k == KIND_REPLY) ? 5 : 2) frame.push_back(8'($urandom));
        idx = 0;
        while (idx < 3 && text_slot(k, 2'(idx)) != FLD_SURPLUS) begin
            repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(1, 255)));
            frame.push_back(BYTE_NUL);
            idx++;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
        end
        if (style < 20) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        t_out_word seen;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.msg_kind = out_if.msg_kind;
            seen.field_kind = out_if.field_kind;
            seen.field_byte = out_if.field_byte;
            seen.is_terminator = out_if.is_terminator;
            seen.message_id = out_if.message_id;
            seen.reference_id = out_if.reference_id;
            seen.parse_status = out_if.parse_status;
            seen.datagram_done = out_if.datagram_done;
            if (pending_results.size() == 0) begin
                $error("unexpected result word, field_byte %0h", seen.field_byte);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("msg_kind", want.msg_kind, seen.msg_kind);
                check_field("field_kind", want.field_kind, seen.field_kind);
                check_field("field_byte", want.field_byte, seen.field_byte);
                check_field("is_terminator", want.is_terminator, seen.is_terminator);
                check_field("message_id", want.message_id, seen.message_id);
                check_field("reference_id", want.reference_id, seen.reference_id);
                check_field("parse_status", want.parse_status, seen.parse_status);
                check_field("datagram_done", want.datagram_done, seen.datagram_done);
                results_checked++;
                if (want.datagram_done) begin
                    frames_done++;
                    if (want.parse_status == ST_BAD_KIND) frames_bad_kind++;
                    if (want.parse_status == ST_TRUNCATED) frames_truncated++;
                end
            end
        end
    end

    initial begin : rx_side
        t_rx_mode mode;
        int       cyc;
        int       hold_left;
        mode = RX_OPEN;
        cyc = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cyc % 64 == 0) mode = t_rx_mode'($urandom_range(0, 3));
            cyc++;
            if (hold_request && hold_left == 0) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:  out_if.ready <= 1'b1;
                    RX_COIN:  out_if.ready <= 1'($urandom_range(0, 1));
                    RX_RARE:  out_if.ready <= ($urandom_range(0, 7) != 0);
                    default:  out_if.ready <= (cyc % 7 > 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : tx_side
        int n_frames;
        int random_start;
        i_rst_n = 1'b0;
        in_if.valid <= 1'b0;
        in_if.data_byte <= 8'h00;
        in_if.end_of_datagram <= 1'b0;
        pp_pos = POS_TYPE;
        pp_kind = KIND_CONFIRM;
        pp_fidx = '0;
        pp_id = '0;
        pp_rid = '0;
        pp_bad = 1'b0;

        row_chk(8'h55, 1'b1, KIND_UNKNOWN, FLD_TYPE, 16'h0000, 16'h0000, ST_BAD_KIND);
        row(BYTE_BYE, 1'b0);
        row(8'h12, 1'b0);
        row_chk(8'h34, 1'b1, KIND_BYE, FLD_ID_LO, 16'h1234, 16'h0000, ST_OK);
        row(BYTE_CONFIRM, 1'b0);
        row(8'hFF, 1'b0);
        row_chk(8'hFF, 1'b1, KIND_CONFIRM, FLD_ID_LO, 16'hFFFF, 16'hFFFF, ST_OK);
        row(BYTE_REPLY, 1'b0);
        row_chk(8'h80, 1'b1, KIND_REPLY, FLD_ID_HI, 16'h8000, 16'h0000, ST_TRUNCATED);
        row(BYTE_REPLY, 1'b0);
        row(8'h00, 1'b0);
        row(8'h07, 1'b0);
        row(8'h05, 1'b0);
        row(8'hFF, 1'b0);
        row(8'h00, 1'b0);
        row(BYTE_NUL, 1'b1);
        row(BYTE_AUTH, 1'b0);
        row(8'h00, 1'b0);
        row(8'h01, 1'b0);
        row(BYTE_NUL, 1'b0);
        row(BYTE_NUL, 1'b1);
        row(BYTE_JOIN, 1'b0);
        row_chk(8'hAA, 1'b1, KIND_JOIN, FLD_ID_HI, 16'hAA00, 16'h0000, ST_TRUNCATED);
        row(BYTE_MSG, 1'b0);
        row(8'h00, 1'b0);
        row(8'h00, 1'b1);
        row(BYTE_ERR, 1'b0);
        row(8'h01, 1'b0);
        row(8'h02, 1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) send_word(script[i].b, script[i].last, script[i].lit, script[i].w);
        drain();

        n_frames = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            build_frame();
            foreach (frame[i]) send_word(frame[i], i == frame.size() - 1, 1'b0, '0);
            n_frames++;
            if (n_frames == 15) hold_request = 1'b1;
            if (n_frames == 40) drain();
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("%0d bytes sent, %0d results checked, %0d datagrams closed", bytes_sent,
                 results_checked, frames_done);
        $display("closed with unknown kind: %0d, with header cut short: %0d",
                 frames_bad_kind, frames_truncated);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
